// File: hw/rtl/acv_pkg.sv
// Shared types and constants of the anisotropic conduction velocity block.
// Holds the request and response words and the register map; no dependencies.
`default_nettype none
package acv_pkg;

   // Width of one orientation or direction component.
   localparam int COMPONENT_BITS = 16;
   // Fraction bits of a fiber component; ONE = 2^FRAC_BITS.
   localparam int FRAC_BITS = COMPONENT_BITS - 2;
   localparam int VEL_BITS = 16;
   // Scaling of the transverse term: Q4.12 factor squared gives 2^24.
   localparam int RED_SHIFT = 24;
   localparam logic [15:0] REDUCTION_ONE = 16'd4096;
   localparam logic [15:0] ZERO_THR_RESET = 16'd1;
   // Cycles from an accepted start to the result strobe.
   localparam int PIPE_LATENCY = 21 + 5 * COMPONENT_BITS;

   // Register index, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_ISOTROPIC = 2'd0,
      REG_REDUCTION = 2'd1,
      REG_THRESHOLD = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [VEL_BITS-1:0]              base_velocity;
      logic                             cell_is_void;
      logic signed [COMPONENT_BITS-1:0] fiber_x;
      logic signed [COMPONENT_BITS-1:0] fiber_y;
      logic signed [COMPONENT_BITS-1:0] fiber_z;
      logic signed [COMPONENT_BITS-1:0] dir_x;
      logic signed [COMPONENT_BITS-1:0] dir_y;
      logic signed [COMPONENT_BITS-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic [VEL_BITS-1:0] directional_velocity;
      logic                saturated;
   } rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/acv_isqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
// Carries a sideband word alongside; standalone, no package needed.
`default_nettype none
module acv_isqrt_pipe #(
   parameter int W  = 32,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          valid_i,
   input  wire logic [W-1:0]  x_i,
   input  wire logic [SW-1:0] side_i,
   output logic               valid_o,
   output logic [W/2-1:0]     root_o,
   output logic [SW-1:0]      side_o
);
   localparam int K  = W / 2;
   localparam int HW = W / 2;
   localparam int RW = HW + 1;

   logic          valid_ff [K];
   logic [W-1:0]  x_ff     [K];
   logic [HW-1:0] root_ff  [K];
   logic [RW-1:0] rem_ff   [K];
   logic [SW-1:0] side_ff  [K];

   for (genvar k = 0; k < K; k++) begin : g_stage
      logic          valid_prev;
      logic [W-1:0]  x_prev;
      logic [HW-1:0] root_prev;
      logic [RW-1:0] rem_prev;
      logic [SW-1:0] side_prev;
      logic [RW+1:0] acc;
      logic [RW+1:0] trial;
      logic          take;

      if (k == 0) begin : g_first
         assign valid_prev = valid_i;
         assign x_prev     = x_i;
         assign root_prev  = '0;
         assign rem_prev   = '0;
         assign side_prev  = side_i;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign x_prev     = x_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // Bring down two bits and try root*4+1 against the partial remainder.
      assign acc   = {rem_prev, x_prev[W-1 -: 2]};
      assign trial = (RW+2)'({root_prev, 2'b01});
      assign take  = acc >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[k]    <= x_prev << 2;
         root_ff[k] <= {root_prev[HW-2:0], take};
         rem_ff[k]  <= take ? RW'(acc - trial) : RW'(acc);
         side_ff[k] <= side_prev;
      end
   end

   assign valid_o = valid_ff[K-1];
   assign root_o  = root_ff[K-1];
   assign side_o  = side_ff[K-1];

endmodule
`default_nettype wire

// File: hw/rtl/acv_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Carries a sideband word alongside; standalone, no package needed.
`default_nettype none
module acv_div_pipe #(
   parameter int DW = 16,
   parameter int QB = 16,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          valid_i,
   input  wire logic [DW-1:0] rem_i,
   input  wire logic [QB-1:0] num_i,
   input  wire logic [DW-1:0] den_i,
   input  wire logic [SW-1:0] side_i,
   output logic               valid_o,
   output logic [QB-1:0]      quo_o,
   output logic [SW-1:0]      side_o
);
   logic          valid_ff [QB];
   logic [DW-1:0] rem_ff   [QB];
   logic [QB-1:0] num_ff   [QB];
   logic [DW-1:0] den_ff   [QB];
   logic [SW-1:0] side_ff  [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic          valid_prev;
      logic [DW-1:0] rem_prev;
      logic [QB-1:0] num_prev;
      logic [DW-1:0] den_prev;
      logic [SW-1:0] side_prev;
      logic [DW:0]   acc;
      logic          take;

      if (k == 0) begin : g_first
         assign valid_prev = valid_i;
         assign rem_prev   = rem_i;
         assign num_prev   = num_i;
         assign den_prev   = den_i;
         assign side_prev  = side_i;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign num_prev   = num_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // Shift in the next dividend bit; quotient bits fill the vacated low end.
      assign acc  = {rem_prev, num_prev[QB-1]};
      assign take = acc >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= take ? DW'(acc - {1'b0, den_prev}) : DW'(acc);
         num_ff[k]  <= {num_prev[QB-2:0], take};
         den_ff[k]  <= den_prev;
         side_ff[k] <= side_prev;
      end
   end

   assign valid_o = valid_ff[QB-1];
   assign quo_o   = num_ff[QB-1];
   assign side_o  = side_ff[QB-1];

endmodule
`default_nettype wire

// File: hw/rtl/anisotropic_conduction_velocity.sv
// Top level: register file, front end and glue around the sqrt/divide pipes.
// Depends on acv_pkg, acv_isqrt_pipe and acv_div_pipe.
//
// Usage: drive req_data and raise start; a word is taken at every clock edge
// with start high and busy low. busy is never raised, so a word can enter on
// every cycle. Each word yields exactly one result word on rsp_data, shown for
// one cycle with rsp_valid high, in the order taken. Throughput is one word per
// cycle; the path holds two square roots (one stage per root bit) and three
// dividers (one stage per quotient bit) in series.
// The receiver cannot stall; results must be taken as they appear.
// Registers sit on an APB-style port: isotropic_mode at 0x0,
// transverse_reduction at 0x4, zero_norm_threshold at 0x8; pready is always
// high. Write registers only while no word is in flight.
// Synchronous reset clears the pipeline valid bits and restores register
// defaults (isotropic off, reduction 1.0, zero threshold 1); words in flight
// at reset are dropped.
`default_nettype none
module anisotropic_conduction_velocity (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire acv_pkg::req_type req_data,
   output logic                 rsp_valid,
   output acv_pkg::rsp_type     rsp_data,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [3:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import acv_pkg::*;

   localparam int CB   = COMPONENT_BITS;
   localparam int F    = FRAC_BITS;
   localparam int QB2  = 2 * F + 1;
   localparam int CW   = (2 * CB > 32) ? 2 * CB : 32;
   localparam logic [CB-1:0]  C_MAX = CB'(1) << (CB - 1);
   localparam logic [QB2-1:0] ONE2  = QB2'(1) << (2 * F);

   typedef struct packed {
      logic [VEL_BITS-1:0] v;
      logic                is_void;
      logic                bypass;
   } tag_type;

   localparam int TW = $bits(tag_type);

   // Configuration registers and values derived from them.
   logic        iso_ff;
   logic [15:0] red_ff;
   logic [15:0] thr_ff;
   logic [31:0] rr_ff,  rr_in;
   logic [31:0] thr2_ff, thr2_in;
   logic [15:0] red_clamped;
   logic        wr_en;
   reg_index_type wr_index;

   assign pready   = 1'b1;
   assign busy     = 1'b0;
   assign wr_en    = psel && penable && pwrite;
   assign wr_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff <= 1'b0;
         red_ff <= REDUCTION_ONE;
         thr_ff <= ZERO_THR_RESET;
      end else if (wr_en) begin
         case (wr_index)
            REG_ISOTROPIC: iso_ff <= pwdata[0];
            REG_REDUCTION: red_ff <= pwdata[15:0];
            REG_THRESHOLD: thr_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_ISOTROPIC: prdata = {31'd0, iso_ff};
         REG_REDUCTION: prdata = {16'd0, red_ff};
         REG_THRESHOLD: prdata = {16'd0, thr_ff};
         default:       prdata = '0;
      endcase
   end

   // Squared reduction factor and squared threshold, refreshed every cycle.
   assign red_clamped = (red_ff < REDUCTION_ONE) ? REDUCTION_ONE : red_ff;
   assign rr_in       = red_clamped * red_clamped;
   assign thr2_in     = thr_ff * thr_ff;

   always_ff @(posedge clock) begin
      rr_ff   <= rr_in;
      thr2_ff <= thr2_in;
   end

   // Stage 1: component products.
   logic                 s1_valid_ff;
   logic [VEL_BITS-1:0]  s1_v_ff;
   logic                 s1_void_ff;
   logic [2*CB-1:0]      s1_oo_ff [3];
   logic [2*CB-1:0]      s1_dd_ff [3];
   logic signed [2*CB-1:0] s1_od_ff [3];
   logic signed [CB-1:0] fib [3];
   logic signed [CB-1:0] dir [3];

   assign fib[0] = req_data.fiber_x;
   assign fib[1] = req_data.fiber_y;
   assign fib[2] = req_data.fiber_z;
   assign dir[0] = req_data.dir_x;
   assign dir[1] = req_data.dir_y;
   assign dir[2] = req_data.dir_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_v_ff    <= req_data.base_velocity;
      s1_void_ff <= req_data.cell_is_void;
      for (int i = 0; i < 3; i++) begin
         s1_oo_ff[i] <= fib[i] * fib[i];
         s1_dd_ff[i] <= dir[i] * dir[i];
         s1_od_ff[i] <= fib[i] * dir[i];
      end
   end

   // Stage 2: norms, dot magnitude and the bypass decision.
   logic [2*CB-1:0]      o2, d2;
   logic signed [2*CB:0] dsum;
   logic [2*CB:0]        dabs;
   logic                 zero_vec;
   logic                 s2_valid_ff;
   logic [2*CB-1:0]      s2_d2_ff;
   logic [2*CB-1:0]      s2_dotm_ff;
   tag_type              s2_tag_ff;

   assign o2   = s1_oo_ff[0] + s1_oo_ff[1] + s1_oo_ff[2];
   assign d2   = s1_dd_ff[0] + s1_dd_ff[1] + s1_dd_ff[2];
   assign dsum = (2*CB+1)'(s1_od_ff[0]) + (2*CB+1)'(s1_od_ff[1])
               + (2*CB+1)'(s1_od_ff[2]);
   assign dabs = dsum[2*CB] ? (2*CB+1)'(-dsum) : (2*CB+1)'(dsum);
   assign zero_vec = (o2 == '0) || (d2 == '0)
                  || (CW'(o2) < CW'(thr2_ff)) || (CW'(d2) < CW'(thr2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_d2_ff          <= d2;
      s2_dotm_ff        <= dabs[2*CB-1:0];
      s2_tag_ff.v       <= s1_v_ff;
      s2_tag_ff.is_void <= s1_void_ff;
      s2_tag_ff.bypass  <= iso_ff || zero_vec;
   end

   // Norm of the direction vector.
   logic                  nd_valid;
   logic [CB-1:0]         nd_root;
   logic [2*CB+TW-1:0]    nd_side;

   acv_isqrt_pipe #(.W(2*CB), .SW(2*CB+TW)) u_sqrt_dir (
      .clock   (clock),
      .reset   (reset),
      .valid_i (s2_valid_ff),
      .x_i     (s2_d2_ff),
      .side_i  ({s2_dotm_ff, s2_tag_ff}),
      .valid_o (nd_valid),
      .root_o  (nd_root),
      .side_o  (nd_side)
   );

   // Cosine divide setup: an oversized quotient is caught up front.
   logic [CB-1:0]   nd;
   logic [2*CB-1:0] nd_dotm;
   logic            c_ov;
   logic            cp_valid_ff;
   logic [CB-1:0]   cp_rem_ff, cp_num_ff, cp_den_ff;
   logic            cp_ov_ff;
   tag_type         cp_tag_ff;

   assign nd      = (nd_root == '0) ? CB'(1) : nd_root;
   assign nd_dotm = nd_side[2*CB+TW-1:TW];
   assign c_ov    = nd_dotm[2*CB-1:CB] >= nd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_valid_ff <= 1'b0;
      end else begin
         cp_valid_ff <= nd_valid;
      end
   end

   always_ff @(posedge clock) begin
      cp_rem_ff <= c_ov ? '0 : nd_dotm[2*CB-1:CB];
      cp_num_ff <= nd_dotm[CB-1:0];
      cp_den_ff <= nd;
      cp_ov_ff  <= c_ov;
      cp_tag_ff <= tag_type'(nd_side[TW-1:0]);
   end

   logic             c_valid;
   logic [CB-1:0]    c_quo;
   logic [TW:0]      c_side;

   acv_div_pipe #(.DW(CB), .QB(CB), .SW(TW+1)) u_div_cos (
      .clock   (clock),
      .reset   (reset),
      .valid_i (cp_valid_ff),
      .rem_i   (cp_rem_ff),
      .num_i   (cp_num_ff),
      .den_i   (cp_den_ff),
      .side_i  ({cp_ov_ff, cp_tag_ff}),
      .valid_o (c_valid),
      .quo_o   (c_quo),
      .side_o  (c_side)
   );

   // Clamp the cosine and square it.
   logic [CB-1:0]   c_val;
   logic            m_valid_ff;
   logic [2*CB-1:0] m_c2_ff;
   tag_type         m_tag_ff;

   assign c_val = (c_side[TW] || (c_quo > C_MAX)) ? C_MAX : c_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      m_c2_ff  <= c_val * c_val;
      m_tag_ff <= tag_type'(c_side[TW-1:0]);
   end

   // Squared sine, clamped at zero.
   logic            s_valid_ff;
   logic [2*CB-1:0] s_c2_ff;
   logic [QB2-1:0]  s_s2_ff;
   tag_type         s_tag_ff;
   logic [QB2+RED_SHIFT-1:0] t_num;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_c2_ff  <= m_c2_ff;
      s_s2_ff  <= ((2*CB)'(ONE2) > m_c2_ff) ? QB2'((2*CB)'(ONE2) - m_c2_ff) : '0;
      s_tag_ff <= m_tag_ff;
   end

   // Transverse term: s2 * 2^24 / r^2.
   assign t_num = {s_s2_ff, {RED_SHIFT{1'b0}}};

   logic               t_valid;
   logic [QB2-1:0]     t_quo;
   logic [2*CB+TW-1:0] t_side;

   acv_div_pipe #(.DW(32), .QB(QB2), .SW(2*CB+TW)) u_div_trans (
      .clock   (clock),
      .reset   (reset),
      .valid_i (s_valid_ff),
      .rem_i   (32'(t_num[QB2+RED_SHIFT-1:QB2])),
      .num_i   (t_num[QB2-1:0]),
      .den_i   (rr_ff),
      .side_i  ({s_c2_ff, s_tag_ff}),
      .valid_o (t_valid),
      .quo_o   (t_quo),
      .side_o  (t_side)
   );

   // Sum of the two squared terms.
   logic            q_valid_ff;
   logic [2*CB-1:0] q_ff;
   tag_type         q_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= t_valid;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= t_side[2*CB+TW-1:TW] + (2*CB)'(t_quo);
      q_tag_ff <= tag_type'(t_side[TW-1:0]);
   end

   logic          n_valid;
   logic [CB-1:0] n_root;
   logic [TW-1:0] n_side;

   acv_isqrt_pipe #(.W(2*CB), .SW(TW)) u_sqrt_norm (
      .clock   (clock),
      .reset   (reset),
      .valid_i (q_valid_ff),
      .x_i     (q_ff),
      .side_i  (q_tag_ff),
      .valid_o (n_valid),
      .root_o  (n_root),
      .side_o  (n_side)
   );

   // Final divide setup: a quotient above full scale (or a zero norm) saturates.
   tag_type                n_tag;
   logic [VEL_BITS+F-1:0]  v_num;
   logic                   f_ov;
   logic                   fp_valid_ff;
   logic [CB-1:0]          fp_rem_ff, fp_den_ff;
   logic [VEL_BITS-1:0]    fp_num_ff;
   logic                   fp_ov_ff;
   tag_type                fp_tag_ff;

   assign n_tag = tag_type'(n_side);
   assign v_num = {n_tag.v, {F{1'b0}}};
   assign f_ov  = CB'(v_num[VEL_BITS+F-1:VEL_BITS]) >= n_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_valid_ff <= 1'b0;
      end else begin
         fp_valid_ff <= n_valid;
      end
   end

   always_ff @(posedge clock) begin
      fp_rem_ff <= f_ov ? '0 : CB'(v_num[VEL_BITS+F-1:VEL_BITS]);
      fp_num_ff <= v_num[VEL_BITS-1:0];
      fp_den_ff <= n_root;
      fp_ov_ff  <= f_ov;
      fp_tag_ff <= n_tag;
   end

   logic                f_valid;
   logic [VEL_BITS-1:0] f_quo;
   logic [TW:0]         f_side;
   tag_type             f_tag;

   acv_div_pipe #(.DW(CB), .QB(VEL_BITS), .SW(TW+1)) u_div_vel (
      .clock   (clock),
      .reset   (reset),
      .valid_i (fp_valid_ff),
      .rem_i   (fp_rem_ff),
      .num_i   (fp_num_ff),
      .den_i   (fp_den_ff),
      .side_i  ({fp_ov_ff, fp_tag_ff}),
      .valid_o (f_valid),
      .quo_o   (f_quo),
      .side_o  (f_side)
   );

   assign f_tag = tag_type'(f_side[TW-1:0]);

   // Result selection and output register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      if (f_tag.bypass) begin
         rsp_in.directional_velocity = f_tag.v;
         rsp_in.saturated            = 1'b0;
      end else if (f_tag.is_void) begin
         rsp_in.directional_velocity = '0;
         rsp_in.saturated            = 1'b0;
      end else if (f_side[TW]) begin
         rsp_in.directional_velocity = '1;
         rsp_in.saturated            = 1'b1;
      end else begin
         rsp_in.directional_velocity = f_quo;
         rsp_in.saturated            = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Every accepted word comes out after the fixed latency.
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##PIPE_LATENCY rsp_valid)
      else $error("accepted word did not produce a result on time");

   // No result appears without a word accepted the fixed latency earlier.
   a_latency_back : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result strobe without a matching accepted word");

   // A saturated result always carries full scale.
   a_sat_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.directional_velocity == '1)
      else $error("saturated flag without full-scale velocity");
`endif

endmodule
`default_nettype wire

// File: tb/sv/acv_checker.sv
// Checker for the anisotropic conduction velocity block: watches the request,
// result and register ports, predicts each result word and compares it.
// Depends on acv_pkg.
`default_nettype none
module acv_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire acv_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire acv_pkg::rsp_type rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   input  wire logic             pready,
   output int                    error_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import acv_pkg::*;

   logic        iso_mode;
   logic [15:0] reduction;
   logic [15:0] threshold;
   rsp_type     velocity_queue[$];

   assign pending_count = velocity_queue.size();

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned mag_of(logic signed [15:0] v);
      longint signed s;
      s = v;
      return (s < 0) ? longint'(-s) : longint'(s);
   endfunction

   // Speed along the propagation direction for one request word.
   function automatic rsp_type directional_speed(req_type w);
      rsp_type r;
      logic signed [15:0] f[3];
      logic signed [15:0] d[3];
      longint unsigned f2, d2, thr2, pos, neg, p, dotm, nd, c, c2, s2;
      longint unsigned one, one2, red, rr, t2, q, n, res;
      f = '{w.fiber_x, w.fiber_y, w.fiber_z};
      d = '{w.dir_x, w.dir_y, w.dir_z};
      f2 = 0; d2 = 0; pos = 0; neg = 0;
      for (int i = 0; i < 3; i++) begin
         f2 += mag_of(f[i]) * mag_of(f[i]);
         d2 += mag_of(d[i]) * mag_of(d[i]);
      end
      thr2 = longint'(threshold) * longint'(threshold);
      r.saturated = 1'b0;
      if (iso_mode || f2 == 0 || d2 == 0 || f2 < thr2 || d2 < thr2) begin
         r.directional_velocity = w.base_velocity;
         return r;
      end
      if (w.cell_is_void) begin
         r.directional_velocity = '0;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         p = mag_of(f[i]) * mag_of(d[i]);
         if (f[i][15] != d[i][15]) neg += p;
         else pos += p;
      end
      dotm = (pos >= neg) ? pos - neg : neg - pos;
      nd = int_sqrt(d2);
      if (nd == 0) nd = 1;
      one = 64'd1 << FRAC_BITS;
      one2 = 64'd1 << (2 * FRAC_BITS);
      c = dotm / nd;
      if (c > 2 * one) c = 2 * one;
      c2 = c * c;
      s2 = (one2 > c2) ? one2 - c2 : 0;
      red = (reduction < REDUCTION_ONE) ? REDUCTION_ONE : reduction;
      rr = red * red;
      t2 = (s2 / rr) << RED_SHIFT;
      t2 += ((s2 % rr) << RED_SHIFT) / rr;
      q = c2 + t2;
      n = int_sqrt(q);
      if (n == 0) begin
         r.directional_velocity = 16'hFFFF;
         r.saturated = 1'b1;
         return r;
      end
      res = (longint'(w.base_velocity) * one) / n;
      if (res > 64'hFFFF) begin
         r.directional_velocity = 16'hFFFF;
         r.saturated = 1'b1;
      end else begin
         r.directional_velocity = res[15:0];
      end
      return r;
   endfunction

   // Track registers, queue predictions and compare result words.
   always @(posedge clock) begin
      rsp_type want;
      int      new_errors;
      new_errors = 0;
      if (reset) begin
         iso_mode <= 1'b0;
         reduction <= REDUCTION_ONE;
         threshold <= ZERO_THR_RESET;
         velocity_queue.delete();
         error_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_ISOTROPIC: begin
                  iso_mode <= pwdata[0];
               end
               REG_REDUCTION: begin
                  reduction <= pwdata[15:0];
               end
               REG_THRESHOLD: begin
                  threshold <= pwdata[15:0];
               end
               default: ;
            endcase
         end
         if (start && !busy) velocity_queue.push_back(directional_speed(req_data));
         if (rsp_valid) begin
            if (velocity_queue.size() == 0) begin
               $error("result word with no prediction waiting");
               new_errors++;
            end else begin
               want = velocity_queue.pop_front();
               if (want.directional_velocity !== rsp_data.directional_velocity) begin
                  $error("directional_velocity: expected %0d, got %0d",
                         want.directional_velocity, rsp_data.directional_velocity);
                  new_errors++;
               end
               if (want.saturated !== rsp_data.saturated) begin
                  $error("saturated: expected %0d, got %0d",
                         want.saturated, rsp_data.saturated);
                  new_errors++;
               end
            end
         end
         if (new_errors != 0) error_count <= error_count + new_errors;
      end
   end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench top: clock, reset, register writes and request stimulus for the
// anisotropic conduction velocity block. Depends on acv_pkg and acv_checker.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import acv_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          error_count;
   int          pending_count;
   int          idle_pct;

   always #4 clock = ~clock;

   anisotropic_conduction_velocity dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   acv_checker checker_i (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .error_count, .pending_count
   );

   // APB write: a setup phase, then an access phase.
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // Wait until every predicted word has come back, then let the pipe drain.
   task automatic drain_pipe();
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // Offer one word, idling beforehand at the current rate; start stays high
   // across back-to-back words.
   task automatic send_word(req_type w);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
   endtask

   task automatic stop_sending();
      start <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(signed'($urandom_range(0, 16384)) - 16'sd8192);
         default: return 16'($urandom);
      endcase
   endfunction

   // Unit-ish fiber vectors as often as arbitrary ones, sometimes tiny.
   function automatic req_type rand_word();
      req_type w;
      w.base_velocity = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 600)) : 16'($urandom);
      w.cell_is_void = ($urandom_range(7) == 0);
      case ($urandom_range(4))
         0: begin
            w.fiber_x = 16'sd16384; w.fiber_y = 0; w.fiber_z = 0;
         end
         1: begin
            w.fiber_x = 16'sd11585; w.fiber_y = -16'sd11585; w.fiber_z = 0;
         end
         2: begin
            w.fiber_x = 16'($urandom_range(0, 3)); w.fiber_y = 0; w.fiber_z = 16'($urandom_range(0, 1));
         end
         default: begin
            w.fiber_x = rand_comp(); w.fiber_y = rand_comp(); w.fiber_z = rand_comp();
         end
      endcase
      w.dir_x = rand_comp(); w.dir_y = rand_comp(); w.dir_z = rand_comp();
      if ($urandom_range(9) == 0) begin
         w.dir_y = 0; w.dir_z = 0; w.dir_x = 16'($urandom_range(0, 3));
      end
      return w;
   endfunction

   function automatic req_type make_word(logic [15:0] v, logic vd,
                                         logic signed [15:0] fx, fy, fz, dx, dy, dz);
      req_type w;
      w.base_velocity = v; w.cell_is_void = vd;
      w.fiber_x = fx; w.fiber_y = fy; w.fiber_z = fz;
      w.dir_x = dx; w.dir_y = dy; w.dir_z = dz;
      return w;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_word(rand_word());
      stop_sending();
   endtask

   // Stimulus: directed words, then random phases across register settings.
   initial begin
      idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Along the fiber, across it, zero vectors, void, oversized fiber.
      send_word(make_word(16'h0100, 0, 16384, 0, 0, 100, 0, 0));
      send_word(make_word(16'h0100, 0, 16384, 0, 0, 0, 100, 0));
      send_word(make_word(16'hFFFF, 0, 16384, 0, 0, 0, 0, 5));
      send_word(make_word(16'h0000, 0, 16384, 0, 0, 1, 1, 1));
      send_word(make_word(16'h1234, 0, 0, 0, 0, 7, 0, 0));
      send_word(make_word(16'h1234, 0, 16384, 0, 0, 0, 0, 0));
      send_word(make_word(16'h1234, 1, 16384, 0, 0, 3, 4, 0));
      send_word(make_word(16'hFFFF, 1, 0, 0, 0, 3, 4, 0));
      send_word(make_word(16'h0200, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                          16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_word(make_word(16'hFFFF, 1, 16'sh8000, 16'sh8000, 16'sh8000,
                          16'sh8000, 16'sh8000, 16'sh8000));
      send_word(make_word(16'hFFFF, 0, 16'sh8000, 0, 0, 16'sh7FFF, 0, 0));
      send_word(make_word(16'hFFFF, 0, 16384, 0, 0, -200, 0, 0));
      send_word(make_word(16'hFFFF, 0, 1, 0, 0, 0, 9, 0));
      send_word(make_word(16'h8000, 0, 11585, 11585, 0, 100, -100, 0));
      stop_sending();
      drain_pipe();

      // Strong reduction makes transverse speeds saturate; threshold 0.
      csr_write(REG_REDUCTION, 32'hFFFF);
      csr_write(REG_THRESHOLD, 32'h0);
      send_word(make_word(16'hFFFF, 0, 16384, 0, 0, 0, 50, 0));
      send_word(make_word(16'h0001, 0, 1, 0, 0, 0, 1, 0));
      send_word(make_word(16'h0100, 0, 0, 0, 0, 1, 0, 0));
      stop_sending();
      drain_pipe();
      csr_write(REG_ISOTROPIC, 32'hFFFF_FFFF);
      send_word(make_word(16'hABCD, 1, 16384, 0, 0, 0, 50, 0));
      stop_sending();
      drain_pipe();

      // Random phases: sender idles 30%, then 50% for two phases, then never.
      csr_write(REG_ISOTROPIC, 32'h0);
      csr_write(REG_REDUCTION, 32'h1000);
      csr_write(REG_THRESHOLD, 32'h1);
      idle_pct = 30;
      random_phase(120);
      drain_pipe();
      csr_write(REG_REDUCTION, 32'h0800);
      csr_write(REG_THRESHOLD, 32'hFFFF);
      idle_pct = 50;
      random_phase(60);
      drain_pipe();
      csr_write(REG_REDUCTION, 32'($urandom_range(4096, 65535)));
      csr_write(REG_THRESHOLD, 32'($urandom_range(0, 300)));
      random_phase(120);
      drain_pipe();
      csr_write(REG_REDUCTION, 32'h3000);
      csr_write(REG_THRESHOLD, 32'h2);
      csr_write(REG_ISOTROPIC, 32'h1);
      idle_pct = 0;
      random_phase(40);
      drain_pipe();
      csr_write(REG_ISOTROPIC, 32'h0);
      random_phase(160);
      drain_pipe();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

// File: anisotropic_conduction_velocity.f
hw/rtl/acv_pkg.sv
hw/rtl/acv_isqrt_pipe.sv
hw/rtl/acv_div_pipe.sv
hw/rtl/anisotropic_conduction_velocity.sv
tb/sv/acv_checker.sv
tb/sv/tb_top.sv
